// ===== rtl/core/tpp_pkg.sv =====
// Shared types and constants of the transport stream PES packetizer.
package tpp_pkg;

  localparam int unsigned LengthBitsDef = 24;
  localparam int unsigned PktBytes      = 188;
  localparam int unsigned PktWords      = 47;
  localparam int unsigned HdrBytes      = 31;

  localparam logic [1:0] ActVideo   = 2'd0;
  localparam logic [1:0] ActAudio   = 2'd1;
  localparam logic [1:0] ActPayload = 2'd2;

  localparam logic CfgVideoPid = 1'b0;
  localparam logic CfgAudioPid = 1'b1;

  localparam logic [7:0] SyncByte = 8'h47;
  localparam logic [7:0] PadByte  = 8'hFF;

  typedef logic [HdrBytes-1:0][7:0] hdr_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] pos;
    logic [7:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic       valid;
    logic       bank;
    hdr_t       hdr;
    logic [4:0] hlen;
    logic [7:0] fill;
  } pkt_desc_t;

endpackage

// ===== rtl/core/tpp_front.sv =====
// Front end: accepts words, builds packet headers, stores payload, hands off packets.
module tpp_front #(
  parameter int unsigned LENGTH_BITS = tpp_pkg::LengthBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         data_byte_i,
  input  logic [23:0]        frame_length_i,
  input  logic [31:0]        pts_ms_i,
  input  logic [31:0]        dts_ms_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic [1:0]         bank_busy_i,
  output tpp_pkg::buf_wr_t   wr_o,
  output tpp_pkg::pkt_desc_t push_o
);
  import tpp_pkg::*;

  logic [12:0] vpid_q, apid_q;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [7:0] wp_q, wp_d;
  logic       aud_q, aud_d;
  logic [3:0] vcc_q, vcc_d, acc_q, acc_d;
  logic       wb_q, wb_d;
  hdr_t       hdr_q, hdr_d, start_hdr, cont_hdr;
  logic [4:0] hlen_q, hlen_d;

  logic       acc_in;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS:0]   pes_sum;
  logic [15:0] pes_len;
  logic [38:0] p90, d90;
  logic [32:0] pb, db;
  logic [12:0] pid_new, pid_cur;
  logic [3:0]  cc_cur, cc_next;
  logic [7:0]  wp_inc;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic        pkt_done;

  assign in_ready_o  = !bank_busy_i[wb_q];
  assign cfg_ready_o = 1'b1;
  assign acc_in      = in_valid_i && in_ready_o;

  assign len     = LENGTH_BITS'(frame_length_i);
  assign p90     = 39'(pts_ms_i) * 39'd90;
  assign d90     = 39'(dts_ms_i) * 39'd90;
  assign pb      = p90[32:0];
  assign db      = d90[32:0];
  assign pes_sum = (LENGTH_BITS+1)'(len) + ((action_i == ActVideo) ?
                   (LENGTH_BITS+1)'(13) : (LENGTH_BITS+1)'(8));
  assign pes_len = (pes_sum > (LENGTH_BITS+1)'(65535)) ? 16'd0 : pes_sum[15:0];
  assign pid_new = (action_i == ActAudio) ? apid_q : vpid_q;
  assign pid_cur = aud_q ? apid_q : vpid_q;
  assign cc_cur  = aud_q ? acc_q : vcc_q;
  assign cc_next = cc_cur + 4'd1;
  assign wp_inc  = wp_q + 8'd1;
  assign rem_dec = rem_q - LENGTH_BITS'(1);
  assign pkt_done = (wp_inc == 8'(PktBytes)) || (rem_dec == '0);

  always_comb begin
    start_hdr = {HdrBytes{PadByte}};
    start_hdr[0] = SyncByte;
    start_hdr[1] = {3'b010, pid_new[12:8]};
    start_hdr[2] = pid_new[7:0];
    if (action_i == ActVideo) begin
      start_hdr[3]  = {4'h3, vcc_q};
      start_hdr[4]  = 8'h07;
      start_hdr[5]  = 8'h50;
      start_hdr[6]  = db[32:25];
      start_hdr[7]  = db[24:17];
      start_hdr[8]  = db[16:9];
      start_hdr[9]  = db[8:1];
      start_hdr[10] = {db[0], 7'h7E};
      start_hdr[11] = 8'h00;
      start_hdr[12] = 8'h00;
      start_hdr[13] = 8'h00;
      start_hdr[14] = 8'h01;
      start_hdr[15] = 8'hE0;
      start_hdr[16] = pes_len[15:8];
      start_hdr[17] = pes_len[7:0];
      start_hdr[18] = 8'h80;
      start_hdr[19] = 8'hC0;
      start_hdr[20] = 8'h0A;
      start_hdr[21] = {4'h3, pb[32:30], 1'b1};
      start_hdr[22] = pb[29:22];
      start_hdr[23] = {pb[21:15], 1'b1};
      start_hdr[24] = pb[14:7];
      start_hdr[25] = {pb[6:0], 1'b1};
      start_hdr[26] = {4'h1, db[32:30], 1'b1};
      start_hdr[27] = db[29:22];
      start_hdr[28] = {db[21:15], 1'b1};
      start_hdr[29] = db[14:7];
      start_hdr[30] = {db[6:0], 1'b1};
    end else begin
      start_hdr[3]  = {4'h1, acc_q};
      start_hdr[4]  = 8'h00;
      start_hdr[5]  = 8'h00;
      start_hdr[6]  = 8'h01;
      start_hdr[7]  = 8'hC0;
      start_hdr[8]  = pes_len[15:8];
      start_hdr[9]  = pes_len[7:0];
      start_hdr[10] = 8'h80;
      start_hdr[11] = 8'h80;
      start_hdr[12] = 8'h05;
      start_hdr[13] = {4'h2, pb[32:30], 1'b1};
      start_hdr[14] = pb[29:22];
      start_hdr[15] = {pb[21:15], 1'b1};
      start_hdr[16] = pb[14:7];
      start_hdr[17] = {pb[6:0], 1'b1};
    end
    cont_hdr = {HdrBytes{PadByte}};
    cont_hdr[0] = SyncByte;
    cont_hdr[1] = {3'b000, pid_cur[12:8]};
    cont_hdr[2] = pid_cur[7:0];
    cont_hdr[3] = {4'h1, cc_next};
  end

  always_comb begin
    rem_d  = rem_q;
    wp_d   = wp_q;
    aud_d  = aud_q;
    vcc_d  = vcc_q;
    acc_d  = acc_q;
    wb_d   = wb_q;
    hdr_d  = hdr_q;
    hlen_d = hlen_q;
    wr_o   = '{en: 1'b0, bank: wb_q, pos: wp_q, data: data_byte_i};
    push_o = '{valid: 1'b0, bank: wb_q, hdr: hdr_q, hlen: hlen_q, fill: wp_inc};
    if (acc_in) begin
      case (action_i)
        ActVideo, ActAudio: begin
          rem_d = len;
          if (len == '0) begin
            wp_d = 8'd0;
          end else begin
            aud_d  = (action_i == ActAudio);
            hdr_d  = start_hdr;
            hlen_d = (action_i == ActVideo) ? 5'd31 : 5'd18;
            wp_d   = (action_i == ActVideo) ? 8'd31 : 8'd18;
          end
        end
        ActPayload: begin
          if (rem_q != '0) begin
            wr_o.en = 1'b1;
            wp_d  = wp_inc;
            rem_d = rem_dec;
            if (pkt_done) begin
              push_o.valid = 1'b1;
              wb_d = !wb_q;
              if (aud_q) acc_d = cc_next;
              else       vcc_d = cc_next;
              if (rem_dec != '0) begin
                hdr_d  = cont_hdr;
                hlen_d = 5'd4;
                wp_d   = 8'd4;
              end else begin
                wp_d = 8'd0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpid_q <= 13'd256;
      apid_q <= 13'd257;
      rem_q  <= '0;
      wp_q   <= 8'd0;
      aud_q  <= 1'b0;
      vcc_q  <= 4'd0;
      acc_q  <= 4'd0;
      wb_q   <= 1'b0;
      hlen_q <= 5'd0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgVideoPid) vpid_q <= cfg_data_i;
        if (cfg_index_i == CfgAudioPid) apid_q <= cfg_data_i;
      end
      rem_q  <= rem_d;
      wp_q   <= wp_d;
      aud_q  <= aud_d;
      vcc_q  <= vcc_d;
      acc_q  <= acc_d;
      wb_q   <= wb_d;
      hlen_q <= hlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

`ifndef ASSERT_OFF
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> !bank_busy_i[push_o.bank]) else $error("push to busy bank");
  a_push_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> wr_o.en) else $error("push without payload write");
  a_wr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (wr_o.pos >= 8'(hlen_q)) && (wr_o.pos < 8'(PktBytes)))
    else $error("payload write outside packet body");
`endif

endmodule

// ===== rtl/core/tpp_back.sv =====
// Back end: two-bank packet buffer, packet queue and word readout.
module tpp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpp_pkg::buf_wr_t   wr_i,
  input  tpp_pkg::pkt_desc_t push_i,
  output logic [1:0]         bank_busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        packet_word_o,
  output logic               last_word_o
);
  import tpp_pkg::*;

  localparam int unsigned MemWords = 2 * PktWords;

  logic [3:0][7:0] mem [MemWords];
  logic [1:0]  busy_q;
  hdr_t        hdr_q  [2];
  logic [4:0]  hlen_q [2];
  logic [7:0]  fill_q [2];
  logic        rb_q;
  logic [5:0]  k_q;
  logic        s1_v_q, s1_bank_q;
  logic [5:0]  s1_k_q;
  logic [3:0][7:0] rdata_q;
  logic        out_v_q;
  logic [31:0] word_q;
  logic        last_q;

  logic        issue, s1_move, s1_last;
  logic [6:0]  wr_addr, rd_addr;
  logic [31:0] word_d;

  assign bank_busy_o   = busy_q;
  assign out_valid_o   = out_v_q;
  assign packet_word_o = word_q;
  assign last_word_o   = last_q;

  assign s1_move = s1_v_q && (!out_v_q || out_ready_i);
  assign issue   = busy_q[rb_q] && (!s1_v_q || s1_move);
  assign s1_last = (s1_k_q == 6'(PktWords - 1));
  assign wr_addr = (wr_i.bank ? 7'(PktWords) : 7'd0) + 7'(wr_i.pos[7:2]);
  assign rd_addr = (rb_q ? 7'(PktWords) : 7'd0) + 7'(k_q);

  always_comb begin
    logic [7:0] b;
    word_d = '0;
    for (int j = 0; j < 4; j++) begin
      b = {s1_k_q, 2'(j)};
      if (b < 8'(hlen_q[s1_bank_q])) begin
        word_d[31-8*j -: 8] = hdr_q[s1_bank_q][b[4:0]];
      end else if (b < fill_q[s1_bank_q]) begin
        word_d[31-8*j -: 8] = rdata_q[2'(3 - j)];
      end else begin
        word_d[31-8*j -: 8] = PadByte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr][~wr_i.pos[1:0]] <= wr_i.data;
    end
    if (issue) begin
      rdata_q <= mem[rd_addr];
    end
    if (push_i.valid) begin
      hdr_q[push_i.bank]  <= push_i.hdr;
      hlen_q[push_i.bank] <= push_i.hlen;
      fill_q[push_i.bank] <= push_i.fill;
    end
    if (issue) begin
      s1_bank_q <= rb_q;
      s1_k_q    <= k_q;
    end
    if (s1_move) begin
      word_q <= word_d;
      last_q <= s1_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 2'b00;
      rb_q    <= 1'b0;
      k_q     <= 6'd0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (push_i.valid) busy_q[push_i.bank] <= 1'b1;
      if (s1_move && s1_last) busy_q[s1_bank_q] <= 1'b0;
      if (issue) begin
        if (k_q == 6'(PktWords - 1)) begin
          k_q  <= 6'd0;
          rb_q <= !rb_q;
        end else begin
          k_q <= k_q + 6'd1;
        end
      end
      if (issue)        s1_v_q <= 1'b1;
      else if (s1_move) s1_v_q <= 1'b0;
      if (s1_move)          out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_wr_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> !busy_q[wr_i.bank]) else $error("write into queued bank");
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |=> busy_q[$past(push_i.bank)]) else $error("queued bank not marked");
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> busy_q[s1_bank_q]) else $error("readout from free bank");
`endif

endmodule

// ===== rtl/core/ts_pes_packetizer.sv =====
// Top level of the transport stream PES packetizer.
// Start words build the first packet header at once, and payload bytes are written one per
// cycle while the input is ready into a two-bank packet buffer. A finished packet is read out
// as 47 words, one per cycle unless the output stalls, from the buffer's single read port,
// while the front fills the other bank; input stalls only when both banks hold packets not
// yet read out. The PCR extension is always zero since the clock stamps are whole milliseconds.
module ts_pes_packetizer #(
  parameter int unsigned LENGTH_BITS = tpp_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic [23:0] frame_length_i,
  input  logic [31:0] pts_ms_i,
  input  logic [31:0] dts_ms_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] packet_word_o,
  output logic        last_word_o
);
  import tpp_pkg::*;

  buf_wr_t   wr;
  pkt_desc_t push;
  logic [1:0] busy;

  tpp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .data_byte_i,
    .frame_length_i, .pts_ms_i, .dts_ms_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .bank_busy_i(busy), .wr_o(wr), .push_o(push)
  );

  tpp_back u_back (
    .clk_i, .rst_ni, .wr_i(wr), .push_i(push), .bank_busy_o(busy),
    .out_valid_o, .out_ready_i, .packet_word_o, .last_word_o
  );

endmodule
